@@ src/stscu_pkg.sv @@
package stscu_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int ELEM_W   = 32;
    localparam int SUM_W    = 48;
    localparam int COUNT_W  = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Multiplicative hash constant, split into its 32-bit halves.
    localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
    localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

    // One classified element on its way from the front end to the back end.
    typedef struct packed {
        logic [SUM_W-1:0] prefix;
        logic [SUM_W-1:0] want;
        logic             want_ok;
        logic             equal_target;
        logic             over;
        logic             last;
    } q_entry_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

@@ src/stscu_ram.sv @@
module stscu_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16
    )
    (
        input  logic                     clk,
        input  logic                     wr_en,
        input  logic [$clog2(DEPTH)-1:0] wr_addr,
        input  logic [WIDTH-1:0]         wr_data,
        input  logic                     rd_en,
        input  logic [$clog2(DEPTH)-1:0] rd_addr,
        output logic [WIDTH-1:0]         rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/stscu_fifo.sv @@
module stscu_fifo
    import stscu_pkg::*;
    (
        input  logic     clk,
        input  logic     rst_n,
        input  logic     push,
        input  q_entry_t push_data,
        output logic     full,
        input  logic     pop,
        output q_entry_t pop_data,
        output logic     empty
    );

    // Two-entry queue between the front end and the back end.
    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/stscu_front.sv @@
module stscu_front
    import stscu_pkg::*;
    #(
        parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                cfg_wr_en,
        input  logic [SUM_W-1:0]    cfg_wr_data,
        input  logic                in_valid,
        output logic                in_stall,
        input  logic [ELEM_W-1:0]   element_value,
        input  logic                last_element,
        input  back_status_t        back_status,
        output logic                q_push,
        output q_entry_t            q_data,
        input  logic                q_full
    );

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(TABLE_ENTRIES);

    logic [SUM_W-1:0] target_reg;
    logic [SUM_W-1:0] prefix_reg;
    logic [CNT_W-1:0] seen_reg;
    logic             pend_valid_reg;
    logic [SUM_W-1:0] pend_prefix_reg;
    logic             pend_over_reg;
    logic             pend_last_reg;

    logic             accept;
    logic             over;
    logic [SUM_W-1:0] prefix_next;
    logic [SUM_W:0]   want_wide;

    assign q_push   = pend_valid_reg && !q_full;
    assign in_stall = (pend_valid_reg && q_full) || back_status.clearing;
    assign accept   = in_valid && !in_stall;
    assign over     = (seen_reg == CAPACITY);

    assign prefix_next = prefix_reg
        + {{(SUM_W-ELEM_W){element_value[ELEM_W-1]}}, element_value};

    // The difference needs one extra bit; it is a usable key only when it
    // fits back into the signed key width.
    assign want_wide = {pend_prefix_reg[SUM_W-1], pend_prefix_reg}
        - {target_reg[SUM_W-1], target_reg};

    always_comb
    begin
        q_data              = '0;
        q_data.prefix       = pend_prefix_reg;
        q_data.want         = want_wide[SUM_W-1:0];
        q_data.want_ok      = (want_wide[SUM_W] == want_wide[SUM_W-1]);
        q_data.equal_target = (want_wide == '0);
        q_data.over         = pend_over_reg;
        q_data.last         = pend_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            prefix_reg     <= '0;
            seen_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
                if (last_element)
                begin
                    prefix_reg <= '0;
                    seen_reg   <= '0;
                end
                else if (!over)
                begin
                    prefix_reg <= prefix_next;
                    seen_reg   <= seen_reg + CNT_W'(1);
                end
            end
            else if (q_push)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_prefix_reg <= prefix_next;
            pend_over_reg   <= over;
            pend_last_reg   <= last_element;
        end
    end

endmodule

@@ src/stscu_hash.sv @@
module stscu_hash
    import stscu_pkg::*;
    #(
        parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
    )
    (
        input  logic                             clk,
        input  logic                             rst_n,
        input  logic                             start,
        input  logic [SUM_W-1:0]                 key,
        output logic                             done,
        output logic [$clog2(TABLE_ENTRIES)-1:0] slot
    );

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int RW     = SLOT_W + 2;
    localparam logic [RW-1:0] MODULUS = RW'(TABLE_ENTRIES);
    // Scaled reciprocal of the table size that still fits 32 bits. The quotient
    // estimate it gives is exact or one short, so one subtraction finishes it.
    localparam int RECIP_SHIFT = SLOT_W + 31;
    localparam logic [31:0] RECIP   = 32'((64'd1 << RECIP_SHIFT) / 64'(TABLE_ENTRIES));
    localparam logic [31:0] DIVISOR = 32'(TABLE_ENTRIES);

    typedef enum logic [2:0] {H_IDLE, H_MUL0, H_MUL1, H_MUL2, H_QUOT, H_SUB, H_FIX} state_t;

    state_t      state_reg;
    logic [31:0] key_lo_reg;
    logic [15:0] key_hi_reg;
    logic [63:0] prod_reg;
    logic [31:0] acc_reg;
    logic [RW-1:0] rem_reg;
    logic        done_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [RW-1:0] rem_fix;

    assign done = done_reg;
    assign slot = slot_reg;

    // One shared multiplier; the upper product word is built from three
    // partial products in states H_MUL0 to H_MUL2, and two more products reduce it
    // to a slot number.
    always_comb
    begin
        case (state_reg)
            H_MUL0:
            begin
                mul_a = key_lo_reg;
                mul_b = HASH_MUL_LO;
            end
            H_MUL1:
            begin
                mul_a = key_lo_reg;
                mul_b = HASH_MUL_HI;
            end
            H_MUL2:
            begin
                mul_a = {16'd0, key_hi_reg};
                mul_b = HASH_MUL_LO;
            end
            H_QUOT:
            begin
                mul_a = acc_reg;
                mul_b = RECIP;
            end
            H_SUB:
            begin
                mul_a = 32'(prod_reg >> RECIP_SHIFT);
                mul_b = DIVISOR;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // The remainder estimate is below twice the table size.
    assign rem_fix = (rem_reg >= MODULUS) ? rem_reg - MODULUS : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        key_lo_reg <= key[31:0];
                        key_hi_reg <= key[SUM_W-1:32];
                        state_reg  <= H_MUL0;
                    end
                end
                H_MUL0:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= H_MUL1;
                end
                H_MUL1:
                begin
                    acc_reg   <= prod_reg[63:32] + mul_p[31:0];
                    state_reg <= H_MUL2;
                end
                H_MUL2:
                begin
                    acc_reg   <= acc_reg + mul_p[31:0];
                    state_reg <= H_QUOT;
                end
                H_QUOT:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= H_SUB;
                end
                H_SUB:
                begin
                    rem_reg   <= acc_reg[RW-1:0] - mul_p[RW-1:0];
                    state_reg <= H_FIX;
                end
                H_FIX:
                begin
                    slot_reg  <= rem_fix[SLOT_W-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/stscu_back.sv @@
module stscu_back
    import stscu_pkg::*;
    #(
        parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        output logic                q_pop,
        input  q_entry_t            q_data,
        input  logic                q_empty,
        output back_status_t        status,
        output logic                out_valid,
        input  logic                out_stall,
        output logic [COUNT_W-1:0]  running_count,
        output logic                capacity_exceeded,
        output logic                sequence_end
    );

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W = 1 + SUM_W + CNT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  PROBE_MAX = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_HASH, B_READ, B_CMP, B_OUT} state_t;

    state_t              state_reg;
    q_entry_t            cur_reg;
    logic                ins_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    probes_reg;
    logic [COUNT_W-1:0]  match_reg;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_over_reg;
    logic                out_last_reg;

    logic                hash_start;
    logic [SUM_W-1:0]    hash_key;
    logic                hash_done;
    logic [SLOT_W-1:0]   hash_slot;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [WORD_W-1:0]   ram_rdata;

    logic                rd_valid;
    logic [SUM_W-1:0]    rd_key;
    logic [CNT_W-1:0]    rd_occ;
    logic [SUM_W-1:0]    probe_key;
    logic                hit;
    logic                out_free;
    logic                out_load;
    logic [COUNT_W:0]    occ_sum;
    logic [COUNT_W-1:0]  match_occ;
    logic [COUNT_W-1:0]  match_one;

    assign rd_valid  = ram_rdata[WORD_W-1];
    assign rd_key    = ram_rdata[WORD_W-2 -: SUM_W];
    assign rd_occ    = ram_rdata[CNT_W-1:0];
    assign probe_key = ins_reg ? cur_reg.prefix : cur_reg.want;
    assign hit       = !rd_valid || (rd_key == probe_key);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == B_OUT) && out_free;

    assign occ_sum   = {1'b0, match_reg} + (COUNT_W+1)'(rd_occ);
    assign match_occ = occ_sum[COUNT_W] ? COUNT_MAX : occ_sum[COUNT_W-1:0];
    assign match_one = (match_reg == COUNT_MAX) ? COUNT_MAX
                                                : match_reg + COUNT_W'(1);

    assign q_pop           = (state_reg == B_IDLE) && !q_empty;
    assign status.clearing = (state_reg == B_CLEAR);

    assign out_valid         = out_valid_reg;
    assign running_count     = out_count_reg;
    assign capacity_exceeded = out_over_reg;
    assign sequence_end      = out_last_reg;

    always_comb
    begin
        hash_start = 1'b0;
        hash_key   = cur_reg.prefix;
        if (state_reg == B_IDLE && !q_empty && !q_data.over)
        begin
            hash_start = 1'b1;
            hash_key   = q_data.want_ok ? q_data.want : q_data.prefix;
        end
        else if (state_reg == B_CMP && !ins_reg
                 && (hit || probes_reg + CNT_W'(1) == PROBE_MAX))
        begin
            hash_start = 1'b1;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = '0;
        if (state_reg == B_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == B_CMP && ins_reg && hit)
        begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, cur_reg.prefix,
                         rd_valid ? rd_occ + CNT_W'(1) : CNT_W'(1)};
        end
    end

    assign ram_re = (state_reg == B_READ);

    stscu_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (hash_key),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    stscu_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_table
    (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (slot_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            slot_reg      <= '0;
            match_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR:
                begin
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                end
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cur_reg <= q_data;
                        ins_reg <= !q_data.want_ok;
                        if (q_data.over)
                        begin
                            state_reg <= B_OUT;
                        end
                        else
                        begin
                            if (q_data.equal_target)
                            begin
                                match_reg <= match_one;
                            end
                            state_reg <= B_HASH;
                        end
                    end
                end
                B_HASH:
                begin
                    if (hash_done)
                    begin
                        slot_reg   <= hash_slot;
                        probes_reg <= '0;
                        state_reg  <= B_READ;
                    end
                end
                B_READ:
                begin
                    state_reg <= B_CMP;
                end
                B_CMP:
                begin
                    if (hit || probes_reg + CNT_W'(1) == PROBE_MAX)
                    begin
                        if (ins_reg)
                        begin
                            state_reg <= B_OUT;
                        end
                        else
                        begin
                            if (hit && rd_valid)
                            begin
                                match_reg <= match_occ;
                            end
                            ins_reg   <= 1'b1;
                            state_reg <= B_HASH;
                        end
                    end
                    else
                    begin
                        probes_reg <= probes_reg + CNT_W'(1);
                        slot_reg   <= (slot_reg == LAST_SLOT) ? '0
                                                              : slot_reg + SLOT_W'(1);
                        state_reg  <= B_READ;
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        out_count_reg <= match_reg;
                        out_over_reg  <= cur_reg.over;
                        out_last_reg  <= cur_reg.last;
                        if (cur_reg.last)
                        begin
                            match_reg <= '0;
                            slot_reg  <= '0;
                            state_reg <= B_CLEAR;
                        end
                        else
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/subarray_target_sum_counter_unit.sv @@
// Counts the contiguous runs of a signed sequence whose sum equals target_sum.
// Each transfer on the input channel carries one element; each one yields one
// result transfer with the running count of matching runs, a flag for an
// element dropped because the sequence already filled the table, and an echo
// of last_element. A front end keeps the prefix sum and element count, and a
// two-entry queue decouples it from the back end, which owns the prefix-sum
// table: a linear-probing hash table in one RAM of TABLE_ENTRIES words. In
// the back end an element takes two hash computations on the shared 32x32
// multiplier, which also reduces the hash to a slot by reciprocal
// multiplication, plus a read and a compare state for every probe of the
// table RAM, so each collision adds a probe. An element whose lookup key
// falls outside the 48-bit range needs only the insert hash, and a dropped
// element goes straight to the result. After reset, and after every element
// that ends a sequence, the back end clears the table word by word; no input
// transfer is taken then, while configuration writes still are. target_sum
// should be written only while the block is idle.
module subarray_target_sum_counter_unit
    import stscu_pkg::*;
    #(
        parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                cfg_wr_en,
        input  logic [SUM_W-1:0]    cfg_wr_data,
        input  logic                in_valid,
        output logic                in_stall,
        input  logic [ELEM_W-1:0]   element_value,
        input  logic                last_element,
        output logic                out_valid,
        input  logic                out_stall,
        output logic [COUNT_W-1:0]  running_count,
        output logic                capacity_exceeded,
        output logic                sequence_end
    );

    // Queue between the element classifier and the table engine.
    logic         q_push;
    q_entry_t     q_push_data;
    logic         q_full;
    logic         q_pop;
    q_entry_t     q_pop_data;
    logic         q_empty;
    back_status_t back_status;

    stscu_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_value (element_value),
        .last_element  (last_element),
        .back_status   (back_status),
        .q_push        (q_push),
        .q_data        (q_push_data),
        .q_full        (q_full)
    );

    stscu_fifo u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // The back end holds the result register, so a waiting result blocks the
    // front end only once the queue and its pending entry are full.
    stscu_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_pop             (q_pop),
        .q_data            (q_pop_data),
        .q_empty           (q_empty),
        .status            (back_status),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .running_count     (running_count),
        .capacity_exceeded (capacity_exceeded),
        .sequence_end      (sequence_end)
    );

endmodule

@@ src/stscu_checker.sv @@
module stscu_checker
    import stscu_pkg::*;
    (
        input logic               clk,
        input logic               rst_n,
        input logic               in_valid,
        input logic               in_stall,
        input logic               out_valid,
        input logic               out_stall,
        input logic [COUNT_W-1:0] running_count,
        input logic               capacity_exceeded,
        input logic               sequence_end
    );

    logic               in_xfer;
    logic               out_xfer;
    logic [3:0]         pending_reg;
    logic [COUNT_W-1:0] prev_count_reg;
    logic               prev_end_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            prev_count_reg <= '0;
            prev_end_reg   <= 1'b1;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(in_xfer) - 4'(out_xfer);
            if (out_xfer)
            begin
                prev_count_reg <= running_count;
                prev_end_reg   <= sequence_end;
            end
        end
    end

    // A result is only ever produced for an element already taken in.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> pending_reg != 4'd0)
        else $error("result transfer without a pending element");

    // Within a sequence the count never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !prev_end_reg |-> running_count >= prev_count_reg)
        else $error("running count decreased within a sequence");

    // A dropped element leaves the count unchanged and never opens a sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && capacity_exceeded |-> !prev_end_reg
            && running_count == prev_count_reg)
        else $error("dropped element changed the count");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(running_count)
            && $stable(capacity_exceeded) && $stable(sequence_end))
        else $error("stalled result changed");

endmodule

bind subarray_target_sum_counter_unit stscu_checker u_checker (.*);

@@ dv/subarray_target_sum_counter_unit_tb.sv @@
module subarray_target_sum_counter_unit_tb;
    import stscu_pkg::*;

    // The block is built with its default table size, so this is the number of
    // elements that one sequence can take before further ones are dropped.
    localparam int CAPACITY = TABLE_ENTRIES_DEF;

    // These are the bounds of the 48-bit signed prefix range. A lookup key outside
    // them can never match a stored prefix.
    localparam logic signed [63:0] KEY_LO = -64'sd140737488355328;
    localparam logic signed [63:0] KEY_HI = 64'sd140737488355327;

    // This is the wait after the last result before a new target is written. The
    // table may still be clearing then.
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               over;
        logic               seq_end;
    } count_result_t;

    // A row of the directed table. Where typed is set, count is the value that the
    // block must give back. Otherwise the predicted value is used.
    typedef struct {
        logic [ELEM_W-1:0]  elem;
        logic               last;
        bit                 typed;
        int unsigned        count;
    } elem_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [SUM_W-1:0]    cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [ELEM_W-1:0]   element_value;
    logic                last_element;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [COUNT_W-1:0]  running_count;
    logic                capacity_exceeded;
    logic                sequence_end;

    // The predictor keeps its own copy of the block's state here. The table only
    // needs the number of times each prefix has occurred, so a map from the prefix
    // value to its count stands in for the hashed slots.
    logic signed [63:0]  target_value;
    logic signed [63:0]  pred_prefix;
    int unsigned         match_count;
    int unsigned         taken_elems;
    int unsigned         prefix_hits [logic [SUM_W-1:0]];

    count_result_t       pending_counts [$];
    int unsigned         send_idle_pct;
    int unsigned         recv_idle_pct;
    int unsigned         error_count;
    elem_row_t           directed_rows [15];

    subarray_target_sum_counter_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .element_value     (element_value),
        .last_element      (last_element),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .running_count     (running_count),
        .capacity_exceeded (capacity_exceeded),
        .sequence_end      (sequence_end)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // This is the overall limit. A correct run ends far sooner than this.
    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    // The match count saturates at the top of its 20-bit range.
    function automatic int unsigned saturating_add(int unsigned a, int unsigned b);
        longint unsigned t;
        t = longint'(a) + longint'(b);
        return (t > longint'(COUNT_MAX)) ? int'(COUNT_MAX) : int'(t);
    endfunction

    // This advances the predicted state by one accepted element and returns the
    // result that the element must produce.
    task automatic predict_count(input logic [ELEM_W-1:0] elem, input logic last,
                                 output count_result_t res);
        logic signed [63:0] want;
        logic               over;
        over = 1'b0;
        if (taken_elems >= CAPACITY)
        begin
            over = 1'b1;
        end
        else
        begin
            pred_prefix = pred_prefix + {{32{elem[ELEM_W-1]}}, elem};
            // The empty prefix counts once, through a direct equality test.
            if (pred_prefix == target_value)
                match_count = saturating_add(match_count, 1);
            want = pred_prefix - target_value;
            if (want >= KEY_LO && want <= KEY_HI && prefix_hits.exists(want[SUM_W-1:0]))
                match_count = saturating_add(match_count, prefix_hits[want[SUM_W-1:0]]);
            if (prefix_hits.exists(pred_prefix[SUM_W-1:0]))
                prefix_hits[pred_prefix[SUM_W-1:0]]++;
            else
                prefix_hits[pred_prefix[SUM_W-1:0]] = 1;
            taken_elems++;
        end
        res.count   = match_count[COUNT_W-1:0];
        res.over    = over;
        res.seq_end = last;
        // The element that ends a sequence clears everything but the target.
        if (last)
        begin
            pred_prefix = '0;
            match_count = 0;
            taken_elems = 0;
            prefix_hits.delete();
        end
    endtask

    // This sends one element, with random idle cycles in front of it, and waits
    // for the transfer. Valid stays high from one element to the next unless a gap
    // is chosen, so no step ever lowers and raises it again.
    task automatic send_element(input logic [ELEM_W-1:0] elem, input logic last,
                                input bit typed, input int unsigned typed_count);
        count_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid      <= 1'b0;
            element_value <= $urandom;
            last_element  <= 1'($urandom_range(1));
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= elem;
        last_element  <= last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_count(elem, last, res);
        if (typed)
            res.count = typed_count[COUNT_W-1:0];
        pending_counts.insert(pending_counts.size(), res);
    endtask

    // This waits until the block has returned every result and has settled, and
    // then writes a new target.
    task automatic write_target(input logic [SUM_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_counts.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= SUM_W'({$urandom, $urandom});
        target_value = {{16{value[SUM_W-1]}}, value};
    endtask

    // Most elements are small so that sums repeat and runs match often. The rest
    // use the full range and its extremes so that every bit of the field toggles.
    function automatic logic [ELEM_W-1:0] pick_element();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return ELEM_W'($signed($urandom_range(6)) - 3);
        else if (pick < 85)
            return $urandom;
        else if (pick < 93)
            return 32'h7FFF_FFFF;
        else
            return 32'h8000_0000;
    endfunction

    // This sends whole sequences of random length until about the given number of
    // elements have gone.
    task automatic send_sequences(input int unsigned elem_budget);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < elem_budget)
        begin
            len = $urandom_range(12, 1);
            for (int unsigned i = 0; i < len; i++)
                send_element(pick_element(), (i == len - 1), 1'b0, 0);
            sent += len;
        end
    endtask

    // The receiver stalls at random, at the rate that the current phase sets.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Every result transfer is checked against the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("result transfer with no pending expectation: running_count %0d",
                       running_count);
                error_count++;
            end
            else
            begin
                if (running_count !== pending_counts[0].count)
                begin
                    $error("running_count: expected %0d, actual %0d",
                           pending_counts[0].count, running_count);
                    error_count++;
                end
                if (capacity_exceeded !== pending_counts[0].over)
                begin
                    $error("capacity_exceeded: expected %0b, actual %0b",
                           pending_counts[0].over, capacity_exceeded);
                    error_count++;
                end
                if (sequence_end !== pending_counts[0].seq_end)
                begin
                    $error("sequence_end: expected %0b, actual %0b",
                           pending_counts[0].seq_end, sequence_end);
                    error_count++;
                end
                void'(pending_counts.pop_front());
            end
        end
    end

    initial
    begin
        // Rows 1 to 5 follow from the model at a glance with a target of zero.
        // Zero matches the empty prefix once and then the earlier zero prefix
        // too. The largest element alone does not match. After the sequence ends,
        // the most negative element and then the largest one leave no match.
        directed_rows = '{
            '{32'h0000_0000, 1'b0, 1'b1, 1},
            '{32'h0000_0000, 1'b0, 1'b1, 3},
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 3},
            '{32'h8000_0000, 1'b0, 1'b1, 0},
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 0},
            '{32'h0000_0005, 1'b0, 1'b0, 0},
            '{32'hFFFF_FFFB, 1'b0, 1'b0, 0},
            '{32'h0000_0003, 1'b0, 1'b0, 0},
            '{32'hFFFF_FFFD, 1'b0, 1'b0, 0},
            '{32'h0000_0000, 1'b1, 1'b0, 0},
            '{32'h0000_0001, 1'b0, 1'b0, 0},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 0},
            '{32'h0000_0001, 1'b0, 1'b0, 0},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 0},
            '{32'h8000_0000, 1'b1, 1'b0, 0}
        };

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        element_value = '0;
        last_element  = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 78;
        error_count   = 0;
        target_value  = '0;
        pred_prefix   = '0;
        match_count   = 0;
        taken_elems   = 0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // The directed part runs with the target at its reset value of zero.
        foreach (directed_rows[i])
            send_element(directed_rows[i].elem, directed_rows[i].last,
                         directed_rows[i].typed, directed_rows[i].count);

        // With the most negative target, any positive prefix gives a lookup key
        // above the 48-bit range, so only the table lookups below zero can match.
        write_target(48'h8000_0000_0000);
        send_sequences(20);
        // With the largest target, the lookup key of any prefix below -1 falls below the 48-bit range.
        write_target(48'h7FFF_FFFF_FFFF);
        send_sequences(20);

        // In this part the sender idles often and the receiver seldom.
        send_idle_pct = 78;
        recv_idle_pct = 20;
        write_target(48'h0000_0000_0002);
        send_sequences(20);
        write_target({$urandom, 16'($urandom_range(16'hFFFF))});
        send_sequences(20);

        // Neither side idles from here on.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_target(48'hFFFF_FFFF_FFFF);
        send_sequences(20);

        // A target of zero with small elements gives many matches over one sequence
        // that runs past the table's capacity. The elements past the capacity are
        // dropped and flagged, and the last one of them still ends the sequence.
        write_target(48'h0);
        for (int unsigned i = 0; i < CAPACITY + 3; i++)
            send_element(ELEM_W'($signed($urandom_range(2)) - 1), (i == CAPACITY + 2),
                         1'b0, 0);

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_counts.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/stscu_pkg.sv
src/stscu_ram.sv
src/stscu_fifo.sv
src/stscu_front.sv
src/stscu_hash.sv
src/stscu_back.sv
src/subarray_target_sum_counter_unit.sv
src/stscu_checker.sv
dv/subarray_target_sum_counter_unit_tb.sv
